### hw/rtl/rcr_pkg.sv
// Shared types and constants for the range capacity reservation core.
// No dependencies; used by every module of the block.
package rcr_pkg;

    localparam int MAX_STATIONS = 1024;
    localparam int SEG_DEPTH    = MAX_STATIONS - 1;
    localparam int IDX_W        = 10;
    localparam int SC_W         = 11;
    localparam int SEAT_W       = 16;
    localparam int FREE_W       = 17;
    localparam int CFG_IDX_W    = 2;

    // Largest free count a segment can hold; start value of a minimum search
    localparam logic [FREE_W-1:0] FREE_INIT = 17'h0FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_COUNT = 2'd1;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPD,
        ST_UPD_END
    } ctrl_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [FREE_W-1:0] wr_data;
    } mem_req_t;

endpackage

### hw/rtl/range_capacity_reservation_core.sv
// Top level of the range capacity reservation core: config registers,
// seat store and sequencer. Depends on rcr_pkg, rcr_seg_mem, rcr_ctrl.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  item in   | start & !busy          | func, start_station, end_station, seat_count
//  result    | done (one-cycle beat)  | status
//  config    | cfg_we                 | cfg_index, cfg_data
//
// A load or a rejected/empty request ends in ST_IDLE; its result appears the next cycle.
// A booked request scans its segments in ST_SCAN and ST_SCAN_END, one seat store entry
// per cycle through its single read port; a refusal appears the cycle after. If granted,
// the subtract pass runs through ST_UPD and ST_UPD_END, and busy holds through both.
// Reset presets the sequencer and config registers; the seat store needs no clearing.
// The receiver cannot stall: each result beat is shown for one cycle only.
module range_capacity_reservation_core
    import rcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [IDX_W-1:0]     start_station,
    input  logic [IDX_W-1:0]     end_station,
    input  logic [SEAT_W-1:0]    seat_count,
    output logic                 done,
    output logic [1:0]           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEAT_W-1:0]    cfg_data
);

    logic [SEAT_W-1:0] capacity_reg;
    logic [SC_W-1:0]   station_count_reg;
    logic [IDX_W-1:0]  seg_count;
    logic [FREE_W-1:0] rd_data;
    mem_req_t          mem_req;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= '0;
            station_count_reg <= SC_W'(MAX_STATIONS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPACITY:      capacity_reg      <= cfg_data;
                CFG_STATION_COUNT: station_count_reg <= cfg_data[SC_W-1:0];
                default:           capacity_reg      <= capacity_reg;
            endcase
        end
    end

    // Clamp station count and derive segments in use
    always_comb
    begin
        if (station_count_reg == '0)
        begin
            seg_count = '0;
        end
        else if (station_count_reg > SC_W'(MAX_STATIONS))
        begin
            seg_count = IDX_W'(SEG_DEPTH);
        end
        else
        begin
            seg_count = IDX_W'(station_count_reg - 1'b1);
        end
    end

    rcr_seg_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    rcr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .start_station (start_station),
        .end_station   (end_station),
        .seat_count    (seat_count),
        .capacity      (capacity_reg),
        .seg_count     (seg_count),
        .rd_data       (rd_data),
        .mem_req       (mem_req),
        .busy          (busy),
        .done          (done),
        .status        (status)
    );

endmodule

### hw/rtl/rcr_seg_mem.sv
// Free seat store: one entry per segment, one write and one read port.
// Read data is registered, ready the cycle after the read. Depends on rcr_pkg.
module rcr_seg_mem
    import rcr_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [FREE_W-1:0] rd_data
);

    logic [FREE_W-1:0] mem [SEG_DEPTH];
    logic [FREE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/rcr_ctrl.sv
// Sequencer: load writes, range check, minimum scan and subtract pass over the seat store.
// Depends on rcr_pkg; drives rcr_seg_mem through a mem_req_t beat.
module rcr_ctrl
    import rcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  logic [IDX_W-1:0]  start_station,
    input  logic [IDX_W-1:0]  end_station,
    input  logic [SEAT_W-1:0] seat_count,
    input  logic [SEAT_W-1:0] capacity,
    input  logic [IDX_W-1:0]  seg_count,
    input  logic [FREE_W-1:0] rd_data,
    output mem_req_t          mem_req,
    output logic              busy,
    output logic              done,
    output logic [1:0]        status
);

    ctrl_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  waddr_reg, waddr_next;
    logic [SEAT_W-1:0] want_reg, want_next;
    logic [FREE_W-1:0] min_reg, min_next;
    logic              rvalid_reg, rvalid_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [FREE_W-1:0] min_fold;
    logic [IDX_W-1:0]  ptr_inc;

    // Fold the returning read into the running minimum
    always_comb
    begin
        min_fold = min_reg;
        if (rvalid_reg && ($signed(rd_data) < $signed(min_reg)))
        begin
            min_fold = rd_data;
        end
    end

    assign ptr_inc = ptr_reg + 1'b1;

    // Next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        waddr_next  = waddr_reg;
        want_next   = want_reg;
        min_next    = min_reg;
        rvalid_next = 1'b0;
        done_next   = 1'b0;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        done_next   = 1'b1;
                        status_next = (start_station >= seg_count) ? STATUS_RANGE : STATUS_OK;
                    end
                    else if (start_station >= end_station)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                    end
                    else if (end_station > seg_count)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_RANGE;
                    end
                    else
                    begin
                        first_next = start_station;
                        last_next  = end_station;
                        want_next  = seat_count;
                        ptr_next   = start_station;
                        min_next   = FREE_INIT;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rvalid_next = 1'b1;
                min_next    = min_fold;
                ptr_next    = ptr_inc;
                if (ptr_inc == last_reg)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                if ($signed(min_fold) < $signed({1'b0, want_reg}))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_REFUSED;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ptr_next   = first_reg;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                rvalid_next = 1'b1;
                waddr_next  = ptr_reg;
                ptr_next    = ptr_inc;
                if (ptr_inc == last_reg)
                begin
                    state_next = ST_UPD_END;
                end
            end
            ST_UPD_END:
            begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory beat for the current state
    always_comb
    begin
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = ptr_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = waddr_reg;
        mem_req.wr_data = rd_data - {1'b0, want_reg};
        case (state_reg)
            ST_IDLE:
            begin
                mem_req.wr_en   = start && (func == FUNC_LOAD) && (start_station < seg_count);
                mem_req.wr_addr = start_station;
                mem_req.wr_data = {1'b0, capacity} - {1'b0, seat_count};
            end
            ST_SCAN:
            begin
                mem_req.rd_en = 1'b1;
            end
            ST_UPD:
            begin
                mem_req.rd_en = 1'b1;
                mem_req.wr_en = rvalid_reg;
            end
            ST_UPD_END:
            begin
                mem_req.wr_en = rvalid_reg;
            end
            default:
            begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        waddr_reg <= waddr_next;
        want_reg  <= want_next;
        min_reg   <= min_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    // A result only follows an accepted item or the end of a pass
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(start) || $past(state_reg != ST_IDLE)))
        else $error("result without a cause");

    // Returned read data always answers an issued read
    a_rvalid_read: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> $past(mem_req.rd_en))
        else $error("read data valid without a read");

    // Scan pointer stays inside the requested range while reading
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_UPD) |-> (ptr_reg < last_reg))
        else $error("pointer ran past the range");

    // Write-back in the subtract pass never hits the entry being read
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && mem_req.wr_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("read and write of the same entry");

endmodule
